// File: rtl/fixed_point_calculator_alu_assert.svh
// Assertion macros used by rtl/fixed_point_calculator_alu.sv.
`ifndef FIXED_POINT_CALCULATOR_ALU_ASSERT_SVH
`define FIXED_POINT_CALCULATOR_ALU_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define FPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define FPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/fpa_pkg.sv
package fpa_pkg;

  localparam int OP_W   = 3;
  localparam int ST_W   = 3;
  localparam int FIELD_W = 32;
  localparam int DEG_HALF_TURN = 180;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MOD  = 3'd4,
    OP_SQRT = 3'd5,
    OP_DEG  = 3'd6,
    OP_INV  = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_DIVZ    = 3'd1,
    ST_INV     = 3'd2,
    ST_SAT     = 3'd3,
    ST_NEGROOT = 3'd4
  } st_t;

  // Control that travels with each transaction down the cell row.
  typedef struct packed {
    logic vld;
    op_t  op;
    logic neg;
    st_t  st;
  } ctl_t;

endpackage

// File: rtl/fpa_if.sv
interface fpa_in_if import fpa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [FIELD_W-1:0] operand_a;
  logic signed [FIELD_W-1:0] operand_b;

  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if import fpa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] result_value;
  logic [ST_W-1:0]           status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// File: rtl/fpa_front.sv
module fpa_front import fpa_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [OP_W-1:0]        in_op,
  input  logic [FIELD_W-1:0]     in_a,
  input  logic [FIELD_W-1:0]     in_b,
  output ctl_t                   ctl_o,
  output logic [W-1:0]           ma_o,
  output logic [W-1:0]           mb_o,
  output logic [W-1:0]           dvs_o,
  output logic [W+F-1:0]         dnum_o,
  output logic [W+F+((W+F)%2)-1:0] srad_o,
  output logic [W-1:0]           res_o
);

  localparam int N  = W + F;
  localparam int NR = N + (N % 2);

  logic [W-1:0]  a, b, ma, mb, sum, dif, sb, res;
  logic          na, nb, ovf_add, ovf_sub;
  op_t           op;
  ctl_t          ctl_nxt, ctl_r;
  logic [W-1:0]  ma_r, mb_r, dvs_r, res_r, dvs_nxt;
  logic [N-1:0]  dnum_r, dnum_nxt;
  logic [NR-1:0] srad_r;

  assign op = op_t'(in_op);
  assign a  = W'(in_a);
  assign b  = W'(in_b);
  assign na = a[W-1];
  assign nb = b[W-1];
  assign ma = na ? (~a + 1'b1) : a;
  assign mb = nb ? (~b + 1'b1) : b;
  assign sb = {1'b1, {(W-1){1'b0}}};

  assign sum     = a + b;
  assign dif     = a - b;
  assign ovf_add = ~(a[W-1] ^ b[W-1]) & (sum[W-1] ^ a[W-1]);
  assign ovf_sub =  (a[W-1] ^ b[W-1]) & (dif[W-1] ^ a[W-1]);

  always_comb begin
    ctl_nxt.vld = in_vld;
    ctl_nxt.op  = op;
    ctl_nxt.neg = 1'b0;
    ctl_nxt.st  = ST_OK;
    res         = '0;
    unique case (op)
      OP_ADD: begin
        res        = ovf_add ? (na ? sb : sb - 1'b1) : sum;
        ctl_nxt.st = ovf_add ? ST_SAT : ST_OK;
      end
      OP_SUB: begin
        res        = ovf_sub ? (na ? sb : sb - 1'b1) : dif;
        ctl_nxt.st = ovf_sub ? ST_SAT : ST_OK;
      end
      OP_MUL: ctl_nxt.neg = na ^ nb;
      OP_DIV: begin
        ctl_nxt.neg = na ^ nb;
        ctl_nxt.st  = (mb == '0) ? ST_DIVZ : ST_OK;
      end
      OP_MOD: begin
        ctl_nxt.neg = na;
        ctl_nxt.st  = (mb == '0) ? ST_DIVZ : ST_OK;
      end
      OP_SQRT: ctl_nxt.st  = na ? ST_NEGROOT : ST_OK;
      OP_DEG:  ctl_nxt.neg = na;
      default: ctl_nxt.st  = ST_INV;
    endcase
  end

  assign dvs_nxt  = (op == OP_DEG) ? W'(DEG_HALF_TURN) : mb;
  assign dnum_nxt = (op == OP_DIV) ? (N'(ma) << F) : N'(ma);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r.vld <= ctl_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.op  <= ctl_nxt.op;
      ctl_r.neg <= ctl_nxt.neg;
      ctl_r.st  <= ctl_nxt.st;
      ma_r      <= ma;
      mb_r      <= mb;
      dvs_r     <= dvs_nxt;
      dnum_r    <= dnum_nxt;
      srad_r    <= NR'(ma) << F;
      res_r     <= res;
    end
  end

  assign ctl_o  = ctl_r;
  assign ma_o   = ma_r;
  assign mb_o   = mb_r;
  assign dvs_o  = dvs_r;
  assign dnum_o = dnum_r;
  assign srad_o = srad_r;
  assign res_o  = res_r;

endmodule

// File: rtl/fpa_cell.sv
module fpa_cell import fpa_pkg::*; #(
  parameter int W   = 32,
  parameter int F   = 16,
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  ctl_t                              ctl_i,
  input  logic [W-1:0]                      ma_i,
  input  logic [W-1:0]                      mb_i,
  input  logic [W-1:0]                      dvs_i,
  input  logic [2*W-1:0]                    acc_i,
  input  logic [W+F-1:0]                    dnum_i,
  input  logic [W-1:0]                      drem_i,
  input  logic [W+F-1:0]                    dquo_i,
  input  logic [W+F+((W+F)%2)-1:0]          srad_i,
  input  logic [(W+F+((W+F)%2))/2:0]        srem_i,
  input  logic [(W+F+((W+F)%2))/2-1:0]      sroot_i,
  input  logic [W-1:0]                      res_i,
  output ctl_t                              ctl_o,
  output logic [W-1:0]                      ma_o,
  output logic [W-1:0]                      mb_o,
  output logic [W-1:0]                      dvs_o,
  output logic [2*W-1:0]                    acc_o,
  output logic [W+F-1:0]                    dnum_o,
  output logic [W-1:0]                      drem_o,
  output logic [W+F-1:0]                    dquo_o,
  output logic [W+F+((W+F)%2)-1:0]          srad_o,
  output logic [(W+F+((W+F)%2))/2:0]        srem_o,
  output logic [(W+F+((W+F)%2))/2-1:0]      sroot_o,
  output logic [W-1:0]                      res_o
);

  localparam int N  = W + F;
  localparam int NR = N + (N % 2);
  localparam int S  = NR / 2;

  // Restoring division: one quotient bit per cell.
  logic [W:0]     dtry;
  logic           dge;
  logic [W-1:0]   drem_nxt;
  logic [2*W-1:0] acc_nxt;
  logic [NR-1:0]  srad_nxt;
  logic [S:0]     srem_nxt;
  logic [S-1:0]   sroot_nxt;

  assign dtry     = {drem_i, dnum_i[N-1]};
  assign dge      = dtry >= {1'b0, dvs_i};
  assign drem_nxt = dge ? W'(dtry - {1'b0, dvs_i}) : W'(dtry);

  generate
    if (IDX < W) begin : g_mul
      assign acc_nxt = mb_i[IDX] ? acc_i + ((2*W)'(ma_i) << IDX) : acc_i;
    end else begin : g_mul_pass
      assign acc_nxt = acc_i;
    end

    if (IDX < S) begin : g_sqrt
      logic [S+2:0] stry, strial;
      logic         sge;
      assign stry      = {srem_i, srad_i[NR-1 -: 2]};
      assign strial    = (S+3)'({sroot_i, 2'b01});
      assign sge       = stry >= strial;
      assign srem_nxt  = sge ? (S+1)'(stry - strial) : (S+1)'(stry);
      assign sroot_nxt = {sroot_i[S-2:0], sge};
      assign srad_nxt  = srad_i << 2;
    end else begin : g_sqrt_pass
      assign srem_nxt  = srem_i;
      assign sroot_nxt = sroot_i;
      assign srad_nxt  = srad_i;
    end
  endgenerate

  ctl_t ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r.vld <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.op  <= ctl_i.op;
      ctl_r.neg <= ctl_i.neg;
      ctl_r.st  <= ctl_i.st;
      ma_o      <= ma_i;
      mb_o      <= mb_i;
      dvs_o     <= dvs_i;
      acc_o     <= acc_nxt;
      dnum_o    <= dnum_i << 1;
      drem_o    <= drem_nxt;
      dquo_o    <= {dquo_i[N-2:0], dge};
      srad_o    <= srad_nxt;
      srem_o    <= srem_nxt;
      sroot_o   <= sroot_nxt;
      res_o     <= res_i;
    end
  end

  assign ctl_o = ctl_r;

endmodule

// File: rtl/fpa_back.sv
module fpa_back import fpa_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  ctl_t                         ctl_i,
  input  logic [2*W-1:0]               acc_i,
  input  logic [W-1:0]                 drem_i,
  input  logic [W+F-1:0]               dquo_i,
  input  logic [(W+F+((W+F)%2))/2-1:0] sroot_i,
  input  logic [W-1:0]                 res_i,
  output logic [W-1:0]                 val_o,
  output st_t                          st_o
);

  localparam int N  = W + F;
  localparam int MW = (2 * W > N) ? 2 * W : N;

  logic [MW-1:0] mag, lim;
  logic [W-1:0]  m;

  assign lim = ctl_i.neg ? MW'({1'b1, {(W-1){1'b0}}}) : MW'({1'b0, {(W-1){1'b1}}});

  always_comb begin
    mag = '0;
    unique case (ctl_i.op)
      OP_MUL:         mag = MW'(acc_i >> F);
      OP_DIV, OP_DEG: mag = MW'(dquo_i);
      OP_MOD:         mag = MW'(drem_i);
      OP_SQRT:        mag = MW'(sroot_i);
      default:        mag = '0;
    endcase
  end

  always_comb begin
    m     = '0;
    val_o = '0;
    st_o  = ctl_i.st;
    if (ctl_i.op == OP_ADD || ctl_i.op == OP_SUB) begin
      val_o = res_i;
    end else if (ctl_i.st == ST_OK) begin
      // Clamp to the signed limit on the side of the result.
      if (mag > lim) begin
        m    = W'(lim);
        st_o = ST_SAT;
      end else begin
        m = W'(mag);
      end
      val_o = ctl_i.neg ? (~m + 1'b1) : m;
    end
  end

endmodule

// File: rtl/fixed_point_calculator_alu.sv
// Stages from input to result:
//   one operand stage, one cell per quotient bit of the divider row, one output register.
// Throughput: one transaction per cycle while the output register is empty or being drained; else the row stalls.
// Reset (rst_n low, synchronous) clears every valid bit; payload is not reset.
`include "fixed_point_calculator_alu_assert.svh"

module fixed_point_calculator_alu import fpa_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  fpa_in_if.sink   in_ch,
  fpa_out_if.source out_ch
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int N  = W + F;
  localparam int NR = N + (N % 2);
  localparam int S  = NR / 2;

  // Row of cells: each cell retires one divide bit, one root bit (the first S
  // cells) and one multiplier partial product (the first W cells).
  ctl_t           ctl_s   [0:N];
  logic [W-1:0]   ma_s    [0:N];
  logic [W-1:0]   mb_s    [0:N];
  logic [W-1:0]   dvs_s   [0:N];
  logic [2*W-1:0] acc_s   [0:N];
  logic [N-1:0]   dnum_s  [0:N];
  logic [W-1:0]   drem_s  [0:N];
  logic [N-1:0]   dquo_s  [0:N];
  logic [NR-1:0]  srad_s  [0:N];
  logic [S:0]     srem_s  [0:N];
  logic [S-1:0]   sroot_s [0:N];
  logic [W-1:0]   res_s   [0:N];

  logic           en;
  logic           out_vld_r;
  logic [W-1:0]   out_val_r, pk_val;
  st_t            out_st_r, pk_st;
  op_t            out_op_r;

  // Advance the row whenever the output register is empty or being drained.
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  fpa_front #(.W(W), .F(F)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_ch.valid),
    .in_op  (in_ch.operation),
    .in_a   (in_ch.operand_a),
    .in_b   (in_ch.operand_b),
    .ctl_o  (ctl_s[0]),
    .ma_o   (ma_s[0]),
    .mb_o   (mb_s[0]),
    .dvs_o  (dvs_s[0]),
    .dnum_o (dnum_s[0]),
    .srad_o (srad_s[0]),
    .res_o  (res_s[0])
  );

  // Start the accumulators of the row from zero.
  assign acc_s[0]   = '0;
  assign drem_s[0]  = '0;
  assign dquo_s[0]  = '0;
  assign srem_s[0]  = '0;
  assign sroot_s[0] = '0;

  generate
    for (genvar k = 0; k < N; k++) begin : g_cell
      fpa_cell #(.W(W), .F(F), .IDX(k)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_i   (ctl_s[k]),
        .ma_i    (ma_s[k]),
        .mb_i    (mb_s[k]),
        .dvs_i   (dvs_s[k]),
        .acc_i   (acc_s[k]),
        .dnum_i  (dnum_s[k]),
        .drem_i  (drem_s[k]),
        .dquo_i  (dquo_s[k]),
        .srad_i  (srad_s[k]),
        .srem_i  (srem_s[k]),
        .sroot_i (sroot_s[k]),
        .res_i   (res_s[k]),
        .ctl_o   (ctl_s[k+1]),
        .ma_o    (ma_s[k+1]),
        .mb_o    (mb_s[k+1]),
        .dvs_o   (dvs_s[k+1]),
        .acc_o   (acc_s[k+1]),
        .dnum_o  (dnum_s[k+1]),
        .drem_o  (drem_s[k+1]),
        .dquo_o  (dquo_s[k+1]),
        .srad_o  (srad_s[k+1]),
        .srem_o  (srem_s[k+1]),
        .sroot_o (sroot_s[k+1]),
        .res_o   (res_s[k+1])
      );
    end
  endgenerate

  // Pick the finished magnitude, clamp and apply the sign; add and subtract pass their result through.
  fpa_back #(.W(W), .F(F)) u_back (
    .ctl_i   (ctl_s[N]),
    .acc_i   (acc_s[N]),
    .drem_i  (drem_s[N]),
    .dquo_i  (dquo_s[N]),
    .sroot_i (sroot_s[N]),
    .res_i   (res_s[N]),
    .val_o   (pk_val),
    .st_o    (pk_st)
  );

  // Output register: hold the transaction until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ctl_s[N].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r <= pk_val;
      out_st_r  <= pk_st;
      out_op_r  <= ctl_s[N].op;
    end
  end

  // Only the low field bits leave the block; narrow data is zero extended.
  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_value = FIELD_W'(out_val_r);
  assign out_ch.status       = out_st_r;

  `FPA_ASSERT_IMP(a_err_zero, clk, rst_n,
    out_vld_r && (out_st_r == ST_DIVZ || out_st_r == ST_INV || out_st_r == ST_NEGROOT),
    out_val_r == '0, "error result carries a nonzero value")
  `FPA_ASSERT_IMP(a_mod_no_sat, clk, rst_n, out_vld_r && out_op_r == OP_MOD,
    out_st_r != ST_SAT, "remainder reported saturation")
  `FPA_ASSERT_IMP(a_addsub_st, clk, rst_n,
    out_vld_r && (out_op_r == OP_ADD || out_op_r == OP_SUB),
    out_st_r == ST_OK || out_st_r == ST_SAT, "add or sub with a bad status")
  `FPA_ASSERT_NXT(a_accept_loads, clk, rst_n, in_ch.valid && in_ch.ready,
    ctl_s[0].vld, "accepted transaction lost at the operand stage")

endmodule
